// ----- design/sssup_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssup_pkg
// Widths, action codes, register indexes and reset values of the stepper
// speed and stall supervisor.
// ----------------------------------------------------------------------------
package sssup_pkg;

    localparam int MOTORS_DEFAULT = 8;

    // item fields
    localparam int ACTION_W = 3;
    localparam int MOTOR_W  = 3;
    localparam int SPEED_W  = 24;
    localparam int POS_W    = 32;
    localparam int FREQ_W   = 22;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEPS_W    = 14;
    localparam int SCALE_W    = 16;
    localparam int ALPHA_W    = 16;
    localparam int LOCK_W     = 7;
    localparam int STOP_W     = 4;

    // shared multiplier
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_TICK        = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_STOP        = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_STALL = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_COUNT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SEED        = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_UNIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_TICKS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_WATCH     = 3'd5;

    // register reset values
    localparam logic [STEPS_W-1:0] STEPS_RESET = 14'd12800;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;
    localparam logic [LOCK_W-1:0]  LOCK_RESET  = 7'd100;
    localparam logic [STOP_W-1:0]  STOP_RESET  = 4'd10;

endpackage

// ----- design/stepper_speed_stall_supervisor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_speed_stall_supervisor_top
// Per-motor speed estimate, stall watch and step frequency, one item at a time.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carries action, motor_index, speed_cmd,
// position and machine_running. Each transfer gives exactly one result on
// out_valid/out_stall: step_freq, direction, freq_update, running, stalled,
// any_stalled and filtered_speed.
// A tick item steps through S_MUL_DELTA, S_MUL_OLD, S_MUL_NEW, S_UPDATE,
// S_MUL_FREQ and S_FINISH (the shared 34x18 multiplier runs four times: delta
// scale, two filter terms, step frequency); other actions go through S_MISC,
// S_MUL_FREQ and S_FINISH, which loads the result into the output register.
// in_stall is high while an item is in work. A finished result sits in the
// output register, so the next item is taken while it waits; when the
// receiver keeps stalling, the following item holds in its last step until
// the output register frees up. Reset clears all per-motor state and loads the
// register defaults. Registers are written through cfg_we/cfg_index/cfg_data
// while idle, a rule for the user; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module stepper_speed_stall_supervisor_top #(
    parameter int MOTORS = sssup_pkg::MOTORS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [sssup_pkg::ACTION_W-1:0]        action,
    input  logic [sssup_pkg::MOTOR_W-1:0]         motor_index,
    input  logic signed [sssup_pkg::SPEED_W-1:0]  speed_cmd,
    input  logic signed [sssup_pkg::POS_W-1:0]    position,
    input  logic                                  machine_running,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [sssup_pkg::FREQ_W-1:0]          step_freq,
    output logic                                  direction,
    output logic                                  freq_update,
    output logic                                  running,
    output logic                                  stalled,
    output logic                                  any_stalled,
    output logic signed [sssup_pkg::SPEED_W-1:0]  filtered_speed,
    input  logic                                  cfg_we,
    input  logic [sssup_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sssup_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int SW     = sssup_pkg::SPEED_W;
    localparam int PW     = sssup_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_DELTA,
        S_MUL_OLD,
        S_MUL_NEW,
        S_UPDATE,
        S_MISC,
        S_MUL_FREQ,
        S_FINISH
    } state_t;

    state_t state_reg;

    // latched item
    logic [sssup_pkg::ACTION_W-1:0] action_reg;
    logic [sssup_pkg::MOTOR_W-1:0]  motor_reg;
    logic signed [SW-1:0]           cmd_reg;
    logic signed [PW-1:0]           pos_reg;
    logic                           mrun_reg;

    // configuration
    logic [sssup_pkg::STEPS_W-1:0] steps_reg;
    logic [sssup_pkg::SCALE_W-1:0] scale_reg;
    logic [sssup_pkg::ALPHA_W-1:0] alpha_reg;
    logic [sssup_pkg::LOCK_W-1:0]  lock_reg;
    logic [sssup_pkg::STOP_W-1:0]  stop_reg;
    logic                          watch_reg;

    // per-motor state
    logic signed [PW-1:0]          prev_pos_reg  [MOTORS];
    logic signed [SW-1:0]          smoothed_reg  [MOTORS];
    logic signed [SW-1:0]          applied_reg   [MOTORS];
    logic [sssup_pkg::LOCK_W-1:0]  stall_cnt_reg [MOTORS];
    logic [sssup_pkg::STOP_W-1:0]  zero_cnt_reg  [MOTORS];
    logic [MOTORS-1:0]             run_reg;
    logic [MOTORS-1:0]             stall_reg;

    // working registers
    logic signed [sssup_pkg::PROD_W-1:0] prod_reg;
    logic signed [sssup_pkg::PROD_W-1:0] acc_reg;
    logic signed [SW-1:0]                sample_reg;
    logic signed [SW-1:0]                spd_reg;
    logic                                upd_reg;

    // result register
    logic                         out_valid_reg;
    logic [sssup_pkg::FREQ_W-1:0] step_freq_reg;
    logic                         direction_reg;
    logic                         freq_update_reg;
    logic                         running_reg;
    logic                         stalled_reg;
    logic                         any_stalled_reg;
    logic signed [SW-1:0]         filtered_reg;

    // combinational
    logic [MIDX_W-1:0]                   m_idx;
    logic                                m_valid;
    logic                                is_tick;
    logic                                in_xfer;
    logic                                out_load;
    logic signed [PW:0]                  delta;
    logic [sssup_pkg::ALPHA_W:0]         alpha_comp;
    logic [SW:0]                         spd_mag;
    logic signed [sssup_pkg::MUL_A_W-1:0] mul_a;
    logic signed [sssup_pkg::MUL_B_W-1:0] mul_b;
    logic signed [sssup_pkg::PROD_W-1:0] prod_next;
    logic signed [SW-1:0]                sample_next;
    logic signed [sssup_pkg::PROD_W-1:0] filt_sum;
    logic signed [SW-1:0]                sm_next;
    logic signed [SW-1:0]                eff;
    logic                                monitor;
    logic                                opposing;
    logic [sssup_pkg::LOCK_W:0]          cnt_next;
    logic                                trip;
    logic signed [SW-1:0]                s_next;
    logic [sssup_pkg::FREQ_W-1:0]        freq_val;
    logic [sssup_pkg::STOP_W:0]          zc_inc;
    logic                                zc_over;
    logic [sssup_pkg::STOP_W-1:0]        zc_next;
    logic                                run_fin;

    assign m_idx    = MIDX_W'(motor_reg);
    assign m_valid  = int'(motor_reg) < MOTORS;
    assign is_tick  = (action_reg == sssup_pkg::ACT_TICK) && m_valid;
    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);

    assign delta      = {pos_reg[PW-1], pos_reg}
                      - {prev_pos_reg[m_idx][PW-1], prev_pos_reg[m_idx]};
    assign alpha_comp = 17'h10000 - {1'b0, alpha_reg};
    assign spd_mag    = spd_reg[SW-1] ? (25'd0 - {spd_reg[SW-1], spd_reg})
                                      : {1'b0, spd_reg};

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            S_MUL_DELTA:
            begin
                mul_a = {delta[PW], delta};
                mul_b = {2'b00, scale_reg};
            end
            S_MUL_OLD:
            begin
                mul_a = {{10{smoothed_reg[m_idx][SW-1]}}, smoothed_reg[m_idx]};
                mul_b = {1'b0, alpha_comp};
            end
            S_MUL_NEW:
            begin
                mul_a = {{10{sample_reg[SW-1]}}, sample_reg};
                mul_b = {2'b00, alpha_reg};
            end
            S_MUL_FREQ:
            begin
                mul_a = {9'd0, spd_mag};
                mul_b = {4'd0, steps_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // scaled delta >> 8, saturated to the speed range
    always_comb
    begin
        if ((&prod_reg[51:31]) || !(|prod_reg[51:31]))
            sample_next = prod_reg[31:8];
        else if (prod_reg[51])
            sample_next = 24'sh800000;
        else
            sample_next = 24'sh7FFFFF;
    end

    assign filt_sum = acc_reg + prod_reg;
    assign sm_next  = filt_sum[39:16];

    // stall watch and applied speed
    always_comb
    begin
        eff      = stall_reg[m_idx] ? '0 : cmd_reg;
        monitor  = mrun_reg && watch_reg;
        opposing = ((eff > 0) && (sm_next < 0)) || ((eff < 0) && (sm_next > 0));
        cnt_next = {1'b0, stall_cnt_reg[m_idx]} + 8'(opposing);
        trip     = monitor && (cnt_next > {1'b0, lock_reg});
        s_next   = trip ? '0 : eff;
    end

    // stopped detection on zero frequency
    assign freq_val = prod_reg[37:16];
    assign zc_inc   = {1'b0, zero_cnt_reg[m_idx]} + 5'd1;
    assign zc_over  = (freq_val == '0) && (zc_inc > {1'b0, stop_reg});
    always_comb
    begin
        if (freq_val != '0)
            zc_next = '0;
        else if (zc_over)
            zc_next = stop_reg;
        else
            zc_next = zc_inc[sssup_pkg::STOP_W-1:0];
        run_fin = (is_tick && zc_over) ? 1'b0 : run_reg[m_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            action_reg      <= '0;
            motor_reg       <= '0;
            cmd_reg         <= '0;
            pos_reg         <= '0;
            mrun_reg        <= 1'b0;
            steps_reg       <= sssup_pkg::STEPS_RESET;
            scale_reg       <= sssup_pkg::SCALE_RESET;
            alpha_reg       <= sssup_pkg::ALPHA_RESET;
            lock_reg        <= sssup_pkg::LOCK_RESET;
            stop_reg        <= sssup_pkg::STOP_RESET;
            watch_reg       <= 1'b1;
            for (int i = 0; i < MOTORS; i++)
            begin
                prev_pos_reg[i]  <= '0;
                smoothed_reg[i]  <= '0;
                applied_reg[i]   <= '0;
                stall_cnt_reg[i] <= '0;
                zero_cnt_reg[i]  <= '0;
            end
            run_reg         <= '0;
            stall_reg       <= '0;
            prod_reg        <= '0;
            acc_reg         <= '0;
            sample_reg      <= '0;
            spd_reg         <= '0;
            upd_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            step_freq_reg   <= '0;
            direction_reg   <= 1'b1;
            freq_update_reg <= 1'b0;
            running_reg     <= 1'b0;
            stalled_reg     <= 1'b0;
            any_stalled_reg <= 1'b0;
            filtered_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sssup_pkg::REG_STEPS_PER_UNIT: steps_reg <= cfg_data[13:0];
                    sssup_pkg::REG_SPEED_SCALE:    scale_reg <= cfg_data;
                    sssup_pkg::REG_FILTER_ALPHA:   alpha_reg <= cfg_data;
                    sssup_pkg::REG_LOCK_LIMIT:     lock_reg  <= cfg_data[6:0];
                    sssup_pkg::REG_STOP_TICKS:     stop_reg  <= cfg_data[3:0];
                    sssup_pkg::REG_LOCK_WATCH:     watch_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            // a reload in the same cycle keeps the register full
            if (out_valid_reg && !out_stall && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        action_reg <= action;
                        motor_reg  <= motor_index;
                        cmd_reg    <= speed_cmd;
                        pos_reg    <= position;
                        mrun_reg   <= machine_running;
                        if ((action == sssup_pkg::ACT_TICK) && (int'(motor_index) < MOTORS))
                            state_reg <= S_MUL_DELTA;
                        else
                            state_reg <= S_MISC;
                    end
                end
                S_MUL_DELTA:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_MUL_OLD;
                end
                S_MUL_OLD:
                begin
                    sample_reg <= sample_next;
                    prod_reg   <= prod_next;
                    state_reg  <= S_MUL_NEW;
                end
                S_MUL_NEW:
                begin
                    acc_reg   <= prod_reg;
                    prod_reg  <= prod_next;
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    smoothed_reg[m_idx] <= sm_next;
                    prev_pos_reg[m_idx] <= pos_reg;
                    if (trip)
                    begin
                        stall_reg[m_idx]     <= 1'b1;
                        stall_cnt_reg[m_idx] <= '0;
                        zero_cnt_reg[m_idx]  <= '0;
                    end
                    else if (monitor)
                        stall_cnt_reg[m_idx] <= cnt_next[sssup_pkg::LOCK_W-1:0];
                    if (s_next != '0)
                        run_reg[m_idx] <= 1'b1;
                    else if (trip)
                        run_reg[m_idx] <= 1'b0;
                    applied_reg[m_idx] <= s_next;
                    upd_reg   <= trip || (s_next != applied_reg[m_idx]);
                    spd_reg   <= s_next;
                    state_reg <= S_MUL_FREQ;
                end
                S_MISC:
                begin
                    if (action_reg == sssup_pkg::ACT_CLEAR_STALL ||
                        action_reg == sssup_pkg::ACT_CLEAR_COUNT)
                    begin
                        for (int i = 0; i < MOTORS; i++)
                            stall_cnt_reg[i] <= '0;
                        if (action_reg == sssup_pkg::ACT_CLEAR_STALL)
                        begin
                            run_reg   <= '0;
                            stall_reg <= '0;
                        end
                    end
                    if (m_valid && action_reg == sssup_pkg::ACT_STOP)
                    begin
                        applied_reg[m_idx]   <= '0;
                        zero_cnt_reg[m_idx]  <= '0;
                        stall_cnt_reg[m_idx] <= '0;
                        run_reg[m_idx]       <= 1'b0;
                    end
                    if (m_valid && action_reg == sssup_pkg::ACT_SEED)
                        prev_pos_reg[m_idx] <= pos_reg;
                    if (m_valid && action_reg != sssup_pkg::ACT_STOP)
                        spd_reg <= applied_reg[m_idx];
                    else
                        spd_reg <= '0;
                    upd_reg   <= m_valid && (action_reg == sssup_pkg::ACT_STOP);
                    state_reg <= S_MUL_FREQ;
                end
                S_MUL_FREQ:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_load)
                    begin
                        if (is_tick)
                        begin
                            zero_cnt_reg[m_idx] <= zc_next;
                            run_reg[m_idx]      <= run_fin;
                        end
                        out_valid_reg   <= 1'b1;
                        step_freq_reg   <= freq_val;
                        direction_reg   <= !spd_reg[SW-1];
                        freq_update_reg <= upd_reg;
                        running_reg     <= m_valid && run_fin;
                        stalled_reg     <= m_valid && stall_reg[m_idx];
                        any_stalled_reg <= |stall_reg;
                        filtered_reg    <= m_valid ? smoothed_reg[m_idx] : '0;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign step_freq      = step_freq_reg;
    assign direction      = direction_reg;
    assign freq_update    = freq_update_reg;
    assign running        = running_reg;
    assign stalled        = stalled_reg;
    assign any_stalled    = any_stalled_reg;
    assign filtered_speed = filtered_reg;

endmodule
